FILE: hdl/mbb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the monochrome bitmap blitter.
// No dependencies; every other file of the block imports this package.
package mbb_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Payload widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 11;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMG_WIDTH     = 3'd0,
        REG_IMG_HEIGHT    = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_MIRROR        = 3'd4,
        REG_SCREEN_WIDTH  = 3'd5,
        REG_SCREEN_HEIGHT = 3'd6
    } cfg_idx_t;

    // Register file contents as written
    typedef struct packed {
        logic [8:0]         img_width;
        logic [8:0]         img_height;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic               mirror;
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
    } cfg_t;

    // One classified byte: lanes that survive clipping, in column order
    typedef struct packed {
        logic [BYTE_W-1:0]  lane_mask;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] row_y;
        logic               mirror;
    } q_entry_t;

endpackage

FILE: hdl/mbb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the bitmap blitter: bitmap bytes,
// drawn pixels and configuration writes. Depends on mbb_pkg.

interface mbb_byte_if import mbb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface mbb_pix_if import mbb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               run_last;

    modport source (output valid, output pixel_x, output pixel_y, output run_last,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input run_last,
                    output ready);
endinterface

interface mbb_cfg_if import mbb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/mbb_front.sv
`timescale 1ns / 1ps
// Front end of the blitter: accepts bitmap bytes, tracks the row and byte
// position and classifies the eight lanes against image and screen bounds.
// Depends on mbb_pkg.
module mbb_front import mbb_pkg::*; #(
    parameter int MAX_IMG_WIDTH  = 256,
    parameter int MAX_IMG_HEIGHT = 256,
    parameter int SCREEN_LIMIT   = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] pixel_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output q_entry_t          push_entry
);

    localparam int WW      = $clog2(MAX_IMG_WIDTH + 1);
    localparam int HW      = $clog2(MAX_IMG_HEIGHT + 1);
    localparam int SCW     = $clog2(SCREEN_LIMIT + 1);
    localparam int BPR_MAX = (MAX_IMG_WIDTH + 7) / 8;
    localparam int BW      = (BPR_MAX > 1) ? $clog2(BPR_MAX) : 1;
    localparam int BPRW    = $clog2(BPR_MAX + 1);
    localparam int RW      = (MAX_IMG_HEIGHT > 1) ? $clog2(MAX_IMG_HEIGHT) : 1;
    localparam int M1      = (WW > 12) ? WW : 12;
    localparam int M2      = (SCW > M1) ? SCW : M1;
    localparam int XW      = M2 + 2;

    logic [BW-1:0] byte_pos_reg, byte_pos_next;
    logic [RW-1:0] row_reg, row_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0]    s1_mask_reg, s1_mask_next;
    logic signed [XW-1:0] s1_base_reg, s1_base_next;
    logic [COORD_W-1:0]   s1_row_y_reg, s1_row_y_next;
    logic                 s1_mirror_reg, s1_mirror_next;

    logic [WW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic [SCW-1:0]       sw_eff, sh_eff;
    logic [WW:0]          bpr_full;
    logic [BPRW-1:0]      bpr;
    logic signed [XW-1:0] dy;
    logic                 row_ok, draw_ok;
    logic [BW+2:0]        col0;
    logic signed [XW-1:0] x_off;
    logic [BYTE_W-1:0]    lit_mask;
    logic [BW:0]          byte_inc;
    logic [RW:0]          row_inc;
    logic                 accept;

    logic signed [XW-1:0] lane_x [BYTE_W];
    logic [BYTE_W-1:0]    keep_mask;
    logic                 s1_advance;

    // Effective sizes after clamping the raw register values
    always_comb
    begin
        if (32'(cfg.img_width) > MAX_IMG_WIDTH)
            w_eff = WW'(MAX_IMG_WIDTH);
        else if (cfg.img_width == '0)
            w_eff = WW'(1);
        else
            w_eff = WW'(cfg.img_width);

        if (32'(cfg.img_height) > MAX_IMG_HEIGHT)
            h_eff = HW'(MAX_IMG_HEIGHT);
        else if (cfg.img_height == '0)
            h_eff = HW'(1);
        else
            h_eff = HW'(cfg.img_height);

        if (32'(cfg.screen_width) > SCREEN_LIMIT)
            sw_eff = SCW'(SCREEN_LIMIT);
        else
            sw_eff = SCW'(cfg.screen_width);

        if (32'(cfg.screen_height) > SCREEN_LIMIT)
            sh_eff = SCW'(SCREEN_LIMIT);
        else
            sh_eff = SCW'(cfg.screen_height);

        bpr_full = ({1'b0, w_eff} + (WW+1)'(7)) >> 3;
        bpr      = BPRW'(bpr_full);
    end

    assign accept     = byte_valid && byte_ready;
    assign s1_advance = s1_valid_reg && (keep_mask == '0 || push_ready);
    assign byte_ready = !s1_valid_reg || s1_advance;

    // Classification of the incoming byte: row clip, lit lanes inside the width
    always_comb
    begin
        dy      = $signed({{(XW-12){cfg.origin_y[11]}}, cfg.origin_y})
                  + $signed(XW'(row_reg));
        row_ok  = !dy[XW-1] && (dy < $signed(XW'(sh_eff)));
        draw_ok = (row_reg < h_eff) && (byte_pos_reg < bpr) && row_ok;
        col0    = {byte_pos_reg, 3'b000};

        for (int b = 0; b < BYTE_W; b++)
        begin
            lit_mask[b] = draw_ok && pixel_byte[BYTE_W-1-b]
                          && ({byte_pos_reg, 3'(b)} < w_eff);
        end

        if (cfg.mirror)
            x_off = $signed(XW'(w_eff)) - $signed(XW'(1)) - $signed(XW'(col0));
        else
            x_off = $signed(XW'(col0));
    end

    // Position counters step on every accepted beat
    always_comb
    begin
        byte_inc      = (BW+1)'(byte_pos_reg) + (BW+1)'(1);
        row_inc       = (RW+1)'(row_reg) + (RW+1)'(1);
        byte_pos_next = byte_pos_reg;
        row_next      = row_reg;
        if (accept)
        begin
            if (byte_inc >= bpr)
            begin
                byte_pos_next = '0;
                if (row_inc >= h_eff)
                    row_next = '0;
                else
                    row_next = RW'(row_inc);
            end
            else
            begin
                byte_pos_next = BW'(byte_inc);
            end
        end
    end

    // First stage register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_mask_next   = s1_mask_reg;
        s1_base_next   = s1_base_reg;
        s1_row_y_next  = s1_row_y_reg;
        s1_mirror_next = s1_mirror_reg;
        if (accept)
        begin
            s1_valid_next  = 1'b1;
            s1_mask_next   = lit_mask;
            s1_base_next   = $signed({{(XW-12){cfg.origin_x[11]}}, cfg.origin_x}) + x_off;
            s1_row_y_next  = COORD_W'(dy);
            s1_mirror_next = cfg.mirror;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Horizontal clip of each lane
    always_comb
    begin
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (s1_mirror_reg)
                lane_x[b] = s1_base_reg - $signed(XW'(b));
            else
                lane_x[b] = s1_base_reg + $signed(XW'(b));
            keep_mask[b] = s1_mask_reg[b] && !lane_x[b][XW-1]
                           && (lane_x[b] < $signed(XW'(sw_eff)));
        end
    end

    assign push_valid           = s1_valid_reg && (keep_mask != '0);
    assign push_entry.lane_mask = keep_mask;
    assign push_entry.base_x    = COORD_W'(s1_base_reg);
    assign push_entry.row_y     = s1_row_y_reg;
    assign push_entry.mirror    = s1_mirror_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mask_reg   <= s1_mask_next;
        s1_base_reg   <= s1_base_next;
        s1_row_y_reg  <= s1_row_y_next;
        s1_mirror_reg <= s1_mirror_next;
    end

`ifndef SYNTH
    // A byte whose lanes are all clipped never reaches the queue.
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_entry.lane_mask != '0))
        else $error("front pushed an empty lane mask");
`endif

endmodule

FILE: hdl/mbb_queue.sv
`timescale 1ns / 1ps
// Short queue of classified bytes between the front and back ends.
// Depends on mbb_pkg.
module mbb_queue import mbb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t           slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (Q_PTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTH
    // Occupancy never goes past the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue occupancy out of range");
    // Pointers agree with the occupancy when the queue is empty.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

FILE: hdl/mbb_back.sv
`timescale 1ns / 1ps
// Back end of the blitter: walks the surviving lanes of one byte in column
// order, emitting one pixel beat per cycle through an output register unless stalled.
// Depends on mbb_pkg.
module mbb_back import mbb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  q_entry_t           pop_entry,
    output logic               pix_valid,
    input  logic               pix_ready,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic               run_last
);

    logic                  active_reg, active_next;
    logic [BYTE_W-1:0]     mask_reg, mask_next;
    logic [COORD_W-1:0]    base_reg, base_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic                  mirror_reg, mirror_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic                  last_reg, last_next;

    logic [2:0]            sel;
    logic [BYTE_W-1:0]     remain;
    logic [COORD_W-1:0]    lane_x;
    logic                  emit;
    logic                  load;

    // Lowest surviving lane is the leftmost image column
    always_comb
    begin
        sel = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = 3'(i);
        end
        remain = mask_reg & ~(BYTE_W'(1) << sel);
        if (mirror_reg)
            lane_x = base_reg - COORD_W'(sel);
        else
            lane_x = base_reg + COORD_W'(sel);
    end

    assign emit      = active_reg && (!out_valid_reg || pix_ready);
    assign pop_ready = !active_reg || (emit && remain == '0);
    assign load      = pop_valid && pop_ready;

    // Working byte: load a new one as soon as the last lane goes out
    always_comb
    begin
        active_next = active_reg;
        mask_next   = mask_reg;
        base_next   = base_reg;
        row_next    = row_reg;
        mirror_next = mirror_reg;
        if (load)
        begin
            active_next = 1'b1;
            mask_next   = pop_entry.lane_mask;
            base_next   = pop_entry.base_x;
            row_next    = pop_entry.row_y;
            mirror_next = pop_entry.mirror;
        end
        else if (emit)
        begin
            mask_next   = remain;
            active_next = (remain != '0);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            x_next         = lane_x;
            y_next         = row_reg;
            last_next      = (remain == '0);
        end
        else if (pix_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pixel_x   = x_reg;
    assign pixel_y   = y_reg;
    assign run_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg   <= mask_next;
        base_reg   <= base_next;
        row_reg    <= row_next;
        mirror_reg <= mirror_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        last_reg   <= last_next;
    end

`ifndef SYNTH
    // A byte being worked on always has a lane left to emit.
    a_active_mask: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (mask_reg != '0))
        else $error("back end active with no lanes left");
`endif

endmodule

FILE: hdl/mono_bitmap_blitter_clip_flip.sv
`timescale 1ns / 1ps
// Top level of the monochrome bitmap blitter: register file and the
// front, queue and back instances. Depends on mbb_pkg, mbb_if, mbb_front,
// mbb_queue and mbb_back.
//
//  Channel  Dir   Beat carries                     Accepted when
//  cfg      sink  index, data (register write)     cfg.valid && cfg.ready
//  bitmap   sink  pixel_byte (eight pixels)        bitmap.valid && bitmap.ready
//  pixels   src   pixel_x, pixel_y, run_last       pixels.valid && pixels.ready
//
// The output delivers one pixel per cycle while pixels.ready is high; a byte
// holds the back end until its drawn pixels are out, and one with none is
// dropped in the front end. Bytes pass front, queue, back and output registers.
// Reset clears the position counters and sets the registers to their defaults;
// no clearing pass is needed. Configuration writes are always taken.
// A two-entry queue lets the front accept bytes while the output is stalled.
module mono_bitmap_blitter_clip_flip import mbb_pkg::*; #(
    parameter int MAX_IMG_WIDTH  = 256,
    parameter int MAX_IMG_HEIGHT = 256,
    parameter int SCREEN_LIMIT   = 2048
) (
    input logic       clk,
    input logic       rst_n,
    mbb_cfg_if.sink   cfg,
    mbb_byte_if.sink  bitmap,
    mbb_pix_if.source pixels
);

    cfg_t     cfg_reg, cfg_next;
    logic     push_valid, push_ready;
    q_entry_t push_entry;
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;

    assign cfg.ready = 1'b1;

    // Register file writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_IMG_WIDTH:     cfg_next.img_width     = cfg.data[8:0];
                REG_IMG_HEIGHT:    cfg_next.img_height    = cfg.data[8:0];
                REG_ORIGIN_X:      cfg_next.origin_x      = $signed(cfg.data[11:0]);
                REG_ORIGIN_Y:      cfg_next.origin_y      = $signed(cfg.data[11:0]);
                REG_MIRROR:        cfg_next.mirror        = cfg.data[0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg.data[11:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg.data[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.img_width     <= 9'd8;
            cfg_reg.img_height    <= 9'd8;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.mirror        <= 1'b0;
            cfg_reg.screen_width  <= 12'd368;
            cfg_reg.screen_height <= 12'd448;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbb_front #(
        .MAX_IMG_WIDTH  (MAX_IMG_WIDTH),
        .MAX_IMG_HEIGHT (MAX_IMG_HEIGHT),
        .SCREEN_LIMIT   (SCREEN_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (bitmap.valid),
        .byte_ready (bitmap.ready),
        .pixel_byte (bitmap.pixel_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    mbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .pix_valid (pixels.valid),
        .pix_ready (pixels.ready),
        .pixel_x   (pixels.pixel_x),
        .pixel_y   (pixels.pixel_y),
        .run_last  (pixels.run_last)
    );

endmodule
